FILE: rtl/core/bdlp_pkg.sv
`default_nettype none

package bdlp_pkg;

  // Register map: index of each configuration register
  localparam int unsigned RegShortPressTicks = 0;
  localparam int unsigned RegLongPressTicks  = 1;

  localparam int unsigned ShortWidth = 8;
  localparam int unsigned LongWidth  = 16;

  localparam logic [ShortWidth-1:0] ShortPressReset = 8'd5;
  localparam logic [LongWidth-1:0]  LongPressReset  = 16'd300;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_t;

  typedef struct packed {
    logic button_down;
    logic check_press;
    logic check_hold;
  } in_item_t;

  typedef struct packed {
    logic press_reported;
    logic hold_reported;
  } out_item_t;

  typedef struct packed {
    logic                  qualified;
    logic [ShortWidth-1:0] debounce_count;
    logic [LongWidth-1:0]  hold_count;
    logic                  seen_down;
    event_t                event_state;
  } press_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/button_debounce_long_press.sv
`default_nettype none

// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  in_item   (button_down, check_press, check_hold)
// out       output     out_valid/out_stall out_item (press_reported, hold_reported)
// config    input      APB psel/penable   short_press_ticks @0x0, long_press_ticks @0x4
//
// One transaction in, one transaction out; a new tick is taken every cycle
// unless in_stall holds it off. Each tick passes the input register, then the tracker update that
// loads the result register. The result register doubles as the state
// commit point, so state only advances when a result moves into it.
// A stalled result holds; the input register keeps accepting while it is
// empty or draining. Synchronous active-high reset clears all tracker state
// and restores the register defaults (5 and 300 ticks).
module button_debounce_long_press
  import bdlp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_item,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_item,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [ShortWidth-1:0] short_press_ticks;
  logic [LongWidth-1:0]  long_press_ticks;

  logic         s1_valid;
  in_item_t     s1_item;
  press_state_t st;
  press_state_t st_next;
  out_item_t    result;
  logic         out_load;
  logic         cfg_write;
  logic         reg_sel;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_sel   = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      short_press_ticks <= ShortPressReset;
      long_press_ticks  <= LongPressReset;
    end else if (cfg_write) begin
      unique case (reg_sel)
        1'(RegShortPressTicks): short_press_ticks <= pwdata[ShortWidth-1:0];
        1'(RegLongPressTicks):  long_press_ticks  <= pwdata[LongWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      1'(RegShortPressTicks): prdata = {{(32-ShortWidth){1'b0}}, short_press_ticks};
      1'(RegLongPressTicks):  prdata = {{(32-LongWidth){1'b0}}, long_press_ticks};
      default:                prdata = '0;
    endcase
  end

  // Advance the input register into the result register when the result
  // slot is empty or being taken this cycle.
  assign out_load = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_item;
    end
  end

  bdlp_step u_step (
    .short_press_ticks (short_press_ticks),
    .long_press_ticks  (long_press_ticks),
    .item              (s1_item),
    .cur               (st),
    .nxt               (st_next),
    .result            (result)
  );

  // Commit tracker state together with the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{qualified: 1'b0, debounce_count: '0, hold_count: '0,
             seen_down: 1'b0, event_state: EV_NONE};
    end else if (out_load) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item <= result;
    end
  end

  // Only one event can be pending, so both reports never fire together.
  a_one_report: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.press_reported && out_item.hold_reported))
    else $error("press and hold reported in the same transaction");

  // A fired report leaves the tracker fully cleared.
  a_clear_on_report: assert property (@(posedge clk) disable iff (rst)
    (out_load && (result.press_reported || result.hold_reported))
      |=> (st.debounce_count == '0 && st.hold_count == '0 &&
           !st.qualified && !st.seen_down && st.event_state == EV_NONE))
    else $error("tracker state not cleared after report");

  // Hold counting only starts after a down tick has been seen.
  a_hold_needs_down: assert property (@(posedge clk) disable iff (rst)
    (st.hold_count != '0 || st.event_state == EV_LONG) |-> st.seen_down)
    else $error("hold progress without a seen down tick");

endmodule

`default_nettype wire

FILE: rtl/core/bdlp_step.sv
`default_nettype none

// One tick of the debounce / hold tracker: next state and report bits.
module bdlp_step
  import bdlp_pkg::*;
(
  input  wire logic [ShortWidth-1:0] short_press_ticks,
  input  wire logic [LongWidth-1:0]  long_press_ticks,
  input  wire in_item_t              item,
  input  wire press_state_t          cur,
  output press_state_t               nxt,
  output out_item_t                  result
);

  press_state_t upd;

  always_comb begin
    upd = cur;
    if (item.button_down) begin
      if (!cur.qualified) begin
        if (cur.debounce_count != {ShortWidth{1'b1}}) begin
          upd.debounce_count = cur.debounce_count + 1'b1;
        end
        if (upd.debounce_count >= short_press_ticks) begin
          upd.qualified = 1'b1;
        end
      end
      if (upd.qualified && cur.seen_down) begin
        if (cur.hold_count != {LongWidth{1'b1}}) begin
          upd.hold_count = cur.hold_count + 1'b1;
        end
        if (upd.hold_count >= long_press_ticks) begin
          upd.event_state = EV_LONG;
        end
      end
      upd.seen_down = 1'b1;
    end else begin
      if (cur.qualified) begin
        if (cur.debounce_count != '0) begin
          upd.debounce_count = cur.debounce_count - 1'b1;
        end else begin
          upd.qualified = 1'b0;
          if (cur.hold_count < long_press_ticks) begin
            upd.event_state = EV_SHORT;
          end
        end
      end else begin
        upd.hold_count = '0;
      end
    end
  end

  // Press and hold reports are formed side by side; either report that fires clears everything.
  always_comb begin
    result.press_reported = item.check_press && (upd.event_state == EV_SHORT);
    result.hold_reported  = item.check_hold && (upd.event_state == EV_LONG);
    if (result.press_reported || result.hold_reported) begin
      nxt = '{qualified: 1'b0, debounce_count: '0, hold_count: '0,
              seen_down: 1'b0, event_state: EV_NONE};
    end else begin
      nxt = upd;
    end
  end

endmodule

`default_nettype wire
